### src/bds_pkg.sv
// shared types and constants for the 2x2 box downsampler
package bds_pkg;

  localparam int CHAN_W = 8;
  localparam int LANES = 4;
  // horizontal pair sum of one channel
  localparam int PAIR_W = CHAN_W + 1;
  // full 2x2 sum of one channel
  localparam int QUAD_W = CHAN_W + 2;

  // source height is fixed by the row counter, not by a parameter
  localparam int MAX_SRC_HEIGHT = 4096;
  localparam int ROW_W = 12;
  localparam int HGT_W = 13;

  // register codes, word index within the config window
  localparam logic [1:0] REG_SRC_WIDTH = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic [CHAN_W-1:0] out_chan3;
    logic last_pixel;
  } pix_out_t;

endpackage

### src/box_downsample_2x2_bgra_top.sv
// 2x2 box downsampler for four-channel 8-bit pixels in raster order
//
// source pixels enter on src_valid/src_stall/src_pixel, one beat per pixel in
// raster order. destination pixels leave on dst_valid/dst_stall/dst_pixel, a
// beat going out on the source beat that completes its 2x2 footprint, with
// last_pixel set on the final destination pixel of the image.
// throughput: one source beat per clock while src_stall is low. a destination
// beat passes from the source beat that completes it through the read stage
// (line store read) and then the output reg (sum and rounding).
// the line store holds the even-row pair sums per destination column; it is
// read on every source beat and written in even rows, and an entry is only
// read back on a later beat, so no forwarding is needed.
// a stalled destination beat holds in the output register while one more
// finished pixel waits in the read stage; src_stall rises only when both are
// full and dst_stall is high.
// reset (rst, synchronous) clears the counters and the pipeline valids and
// loads size 1 into all four registers; the line store is not cleared, an
// entry is always written in an even row before the odd row reads it.
// the apb port sets the sizes; any register write restarts the image at
// column 0, row 0. write only while the block is idle.
module box_downsample_2x2_bgra_top #(
  parameter int MAX_SRC_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  bds_pkg::pix_in_t    src_pixel,
  output logic                dst_valid,
  input  logic                dst_stall,
  output bds_pkg::pix_out_t   dst_pixel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LINE_DEPTH = (MAX_SRC_WIDTH + 1) / 2;
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W = ($clog2(MAX_SRC_WIDTH) > 2) ? $clog2(MAX_SRC_WIDTH) : 2;
  localparam int WID_W = ($clog2(MAX_SRC_WIDTH + 1) > 13) ? $clog2(MAX_SRC_WIDTH + 1) : 13;

  localparam int PW = bds_pkg::PAIR_W;
  localparam int NL = bds_pkg::LANES;
  localparam int HW = bds_pkg::HGT_W;
  localparam int RW = bds_pkg::ROW_W;

  // config registers
  logic [12:0] src_width;
  logic [12:0] src_height;
  logic [11:0] dst_width;
  logic [11:0] dst_height;

  // position of the next source pixel
  logic [COL_W-1:0] col;
  logic [RW-1:0]    row;

  logic [NL-1:0][bds_pkg::CHAN_W-1:0] pending;

  logic [NL-1:0][PW-1:0] line_mem [LINE_DEPTH];
  logic [NL-1:0][PW-1:0] rdata;

  // read stage
  logic                  s1_valid;
  logic [NL-1:0][PW-1:0] s1_pair;
  logic                  s1_odd;
  logic                  s1_last;

  logic cfg_wr;
  logic accept;
  logic out_free;
  logic s1_move;

  logic [WID_W-1:0] w_eff;
  logic [WID_W:0]   half_w;
  logic [WID_W-1:0] dw;
  logic [HW-1:0]    h_eff;
  logic [HW:0]      half_h;
  logic [HW-1:0]    dh;

  logic [WID_W-1:0]  col_ext;
  logic [HW-1:0]     row_ext;
  logic [ADDR_W-1:0] x;
  logic [WID_W-1:0]  x_ext;
  logic [HW-1:0]     y_ext;
  logic              col_odd;
  logic              col_end;
  logic              row_odd;
  logic              row_end;
  logic              have_pair;
  logic              in_dst;
  logic              emit;
  logic              wr_line;

  logic [NL-1:0][bds_pkg::CHAN_W-1:0] px;
  logic [NL-1:0][PW-1:0]              pair;
  logic [NL-1:0][bds_pkg::CHAN_W-1:0] avg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      bds_pkg::REG_SRC_WIDTH:  prdata = {19'd0, src_width};
      bds_pkg::REG_SRC_HEIGHT: prdata = {19'd0, src_height};
      bds_pkg::REG_DST_WIDTH:  prdata = {20'd0, dst_width};
      bds_pkg::REG_DST_HEIGHT: prdata = {20'd0, dst_height};
      default:                 prdata = 32'd0;
    endcase
  end

  // effective sizes: zero reads as one, oversize saturates
  always_comb begin
    if (src_width == 13'd0) begin
      w_eff = WID_W'(1);
    end else if (WID_W'(src_width) > WID_W'(MAX_SRC_WIDTH)) begin
      w_eff = WID_W'(MAX_SRC_WIDTH);
    end else begin
      w_eff = WID_W'(src_width);
    end
    half_w = ({1'b0, w_eff} + (WID_W+1)'(1)) >> 1;
    dw = (WID_W'(dst_width) < half_w[WID_W-1:0]) ? WID_W'(dst_width) : half_w[WID_W-1:0];

    if (src_height == 13'd0) begin
      h_eff = HW'(1);
    end else if (src_height > HW'(bds_pkg::MAX_SRC_HEIGHT)) begin
      h_eff = HW'(bds_pkg::MAX_SRC_HEIGHT);
    end else begin
      h_eff = src_height;
    end
    half_h = ({1'b0, h_eff} + (HW+1)'(1)) >> 1;
    dh = (HW'(dst_height) < half_h[HW-1:0]) ? HW'(dst_height) : half_h[HW-1:0];
  end

  assign px[0] = src_pixel.chan0;
  assign px[1] = src_pixel.chan1;
  assign px[2] = src_pixel.chan2;
  assign px[3] = src_pixel.chan3;

  // position decode and horizontal pairing
  always_comb begin
    col_ext = WID_W'(col);
    row_ext = HW'(row);
    x = ADDR_W'(col >> 1);
    x_ext = WID_W'(col >> 1);
    y_ext = HW'(row >> 1);
    col_odd = col[0];
    row_odd = row[0];
    col_end = (col_ext == w_eff - WID_W'(1));
    row_end = (row_ext == h_eff - HW'(1));
    have_pair = col_odd || col_end;
    for (int k = 0; k < NL; k++) begin
      if (col_odd) begin
        pair[k] = {1'b0, pending[k]} + {1'b0, px[k]};
      end else begin
        pair[k] = {px[k], 1'b0};
      end
    end
    in_dst = have_pair && (x_ext < dw);
    emit = in_dst && (row_odd || row_end) && (y_ext < dh);
    wr_line = in_dst && !row_odd && !row_end;
  end

  assign out_free = !dst_valid || !dst_stall;
  assign s1_move = s1_valid && out_free;
  assign src_stall = s1_valid && !out_free;
  assign accept = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= 13'd1;
      src_height <= 13'd1;
      dst_width <= 12'd1;
      dst_height <= 12'd1;
      col <= '0;
      row <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bds_pkg::REG_SRC_WIDTH:  src_width <= pwdata[12:0];
        bds_pkg::REG_SRC_HEIGHT: src_height <= pwdata[12:0];
        bds_pkg::REG_DST_WIDTH:  dst_width <= pwdata[11:0];
        bds_pkg::REG_DST_HEIGHT: dst_height <= pwdata[11:0];
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + RW'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // line store: read on every beat and used in odd rows, written in even rows
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_line) begin
        line_mem[x] <= pair;
      end
      rdata <= line_mem[x];
      if (!col_odd) begin
        pending <= px;
      end
      s1_pair <= pair;
      s1_odd <= row_odd;
      s1_last <= (x_ext == dw - WID_W'(1)) && (y_ext == dh - HW'(1));
    end
  end

  // vertical sum and rounding
  always_comb begin
    logic [bds_pkg::QUAD_W-1:0] sum;
    for (int k = 0; k < NL; k++) begin
      if (s1_odd) begin
        sum = {1'b0, rdata[k]} + {1'b0, s1_pair[k]} + bds_pkg::QUAD_W'(2);
      end else begin
        sum = {s1_pair[k], 1'b0} + bds_pkg::QUAD_W'(2);
      end
      avg[k] = sum[bds_pkg::QUAD_W-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= emit;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dst_pixel.out_chan0 <= avg[0];
      dst_pixel.out_chan1 <= avg[1];
      dst_pixel.out_chan2 <= avg[2];
      dst_pixel.out_chan3 <= avg[3];
      dst_pixel.last_pixel <= s1_last;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (s1_valid && dst_valid && dst_stall))
    else $error("input stalled while the pipeline has room");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_ext < w_eff)
    else $error("column counter beyond source width");

  a_emit_reaches_stage: assert property (@(posedge clk) disable iff (rst)
    (accept && emit && !cfg_wr) |=> s1_valid)
    else $error("completed pixel lost before the read stage");

  a_move_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> dst_valid)
    else $error("read stage advanced without loading the output");

endmodule
